// ===== rtl/hctb_pkg.sv =====
// Shared types, step codes and status codes of the Huffman code table builder.
`timescale 1ns / 1ps
package hctb_pkg;

   localparam int WEIGHT_W = 40;
   localparam int CODE_W   = 64;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_BUILT = 2'd1;
   localparam logic [1:0] STAT_RANGE     = 2'd2;

   localparam logic [4:0] OP_IDLE     = 5'd0;
   localparam logic [4:0] OP_RD_SYM   = 5'd1;
   localparam logic [4:0] OP_RD_OUT   = 5'd2;
   localparam logic [4:0] OP_HF_START = 5'd3;
   localparam logic [4:0] OP_HF_LD    = 5'd4;
   localparam logic [4:0] OP_HF_LAT   = 5'd5;
   localparam logic [4:0] OP_HF_NEXT  = 5'd6;
   localparam logic [4:0] OP_SD_RL    = 5'd7;
   localparam logic [4:0] OP_SD_RR    = 5'd8;
   localparam logic [4:0] OP_SD_CMP   = 5'd9;
   localparam logic [4:0] OP_MERGE    = 5'd10;
   localparam logic [4:0] OP_TM_TOP   = 5'd11;
   localparam logic [4:0] OP_TM_LAST  = 5'd12;
   localparam logic [4:0] OP_TM_LAT   = 5'd13;
   localparam logic [4:0] OP_PUT      = 5'd14;
   localparam logic [4:0] OP_PU       = 5'd15;
   localparam logic [4:0] OP_PU_CMP   = 5'd16;
   localparam logic [4:0] OP_ROOT_RD  = 5'd17;
   localparam logic [4:0] OP_ROOT_LAT = 5'd18;
   localparam logic [4:0] OP_POP      = 5'd19;
   localparam logic [4:0] OP_VISIT    = 5'd20;
   localparam logic [4:0] OP_LEAF     = 5'd21;
   localparam logic [4:0] OP_PUSH1    = 5'd22;
   localparam logic [4:0] OP_PUSH0    = 5'd23;
   localparam logic [4:0] OP_DONE     = 5'd24;

   typedef struct packed {
      logic [4:0] op;
      logic       accept;
      logic       take_b;
   } cmd_type;

   typedef struct packed {
      logic sd_end;
      logic sd_stop;
      logic k_zero;
      logic cnt_gt1;
      logic pu_root;
      logic pu_stop;
      logic sp_zero;
      logic v_leaf;
      logic n_one;
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/hctb_ctrl.sv =====
// Sequencer of the code table builder: request intake, heap, merge and walk steps.
`timescale 1ns / 1ps
module hctb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_cmd,
   input  logic              req_is_last,
   output logic              req_stall,
   output hctb_pkg::cmd_type cmd,
   input  hctb_pkg::sts_type sts
);

   localparam logic [1:0] CTX_HEAPIFY = 2'd0;
   localparam logic [1:0] CTX_TAKE_A  = 2'd1;
   localparam logic [1:0] CTX_TAKE_B  = 2'd2;

   logic [4:0] state_ff, state_in;
   logic [1:0] ctx_ff, ctx_in;
   logic [4:0] sift_done;

   always_comb begin
      case (ctx_ff)
         CTX_HEAPIFY: sift_done = hctb_pkg::OP_HF_NEXT;
         CTX_TAKE_A:  sift_done = hctb_pkg::OP_TM_TOP;
         default:     sift_done = hctb_pkg::OP_PUT;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ctx_in   = ctx_ff;
      case (state_ff)
         hctb_pkg::OP_IDLE: begin
            if (req_valid) begin
               if (req_cmd == hctb_pkg::CMD_READ) begin
                  state_in = hctb_pkg::OP_RD_SYM;
               end else if (req_is_last) begin
                  state_in = hctb_pkg::OP_HF_START;
               end
            end
         end
         hctb_pkg::OP_RD_SYM: state_in = hctb_pkg::OP_RD_OUT;
         hctb_pkg::OP_RD_OUT: begin
            if (sts.out_free) state_in = hctb_pkg::OP_IDLE;
         end
         hctb_pkg::OP_HF_START: begin
            state_in = sts.n_one ? hctb_pkg::OP_MERGE : hctb_pkg::OP_HF_LD;
         end
         hctb_pkg::OP_HF_LD: state_in = hctb_pkg::OP_HF_LAT;
         hctb_pkg::OP_HF_LAT: begin
            state_in = hctb_pkg::OP_SD_RL;
            ctx_in   = CTX_HEAPIFY;
         end
         hctb_pkg::OP_HF_NEXT: begin
            state_in = sts.k_zero ? hctb_pkg::OP_MERGE : hctb_pkg::OP_HF_LD;
         end
         hctb_pkg::OP_SD_RL: begin
            if (sts.sd_end) begin
               state_in = sift_done;
               if (ctx_ff == CTX_TAKE_A) ctx_in = CTX_TAKE_B;
            end else begin
               state_in = hctb_pkg::OP_SD_RR;
            end
         end
         hctb_pkg::OP_SD_RR: state_in = hctb_pkg::OP_SD_CMP;
         hctb_pkg::OP_SD_CMP: begin
            if (sts.sd_stop) begin
               state_in = sift_done;
               if (ctx_ff == CTX_TAKE_A) ctx_in = CTX_TAKE_B;
            end else begin
               state_in = hctb_pkg::OP_SD_RL;
            end
         end
         hctb_pkg::OP_MERGE: begin
            if (sts.cnt_gt1) begin
               state_in = hctb_pkg::OP_TM_TOP;
               ctx_in   = CTX_TAKE_A;
            end else begin
               state_in = hctb_pkg::OP_ROOT_RD;
            end
         end
         hctb_pkg::OP_TM_TOP:  state_in = hctb_pkg::OP_TM_LAST;
         hctb_pkg::OP_TM_LAST: state_in = hctb_pkg::OP_TM_LAT;
         hctb_pkg::OP_TM_LAT:  state_in = hctb_pkg::OP_SD_RL;
         hctb_pkg::OP_PUT:     state_in = hctb_pkg::OP_PU;
         hctb_pkg::OP_PU: begin
            state_in = sts.pu_root ? hctb_pkg::OP_MERGE : hctb_pkg::OP_PU_CMP;
         end
         hctb_pkg::OP_PU_CMP: begin
            state_in = sts.pu_stop ? hctb_pkg::OP_MERGE : hctb_pkg::OP_PU;
         end
         hctb_pkg::OP_ROOT_RD:  state_in = hctb_pkg::OP_ROOT_LAT;
         hctb_pkg::OP_ROOT_LAT: state_in = hctb_pkg::OP_POP;
         hctb_pkg::OP_POP: begin
            state_in = sts.sp_zero ? hctb_pkg::OP_DONE : hctb_pkg::OP_VISIT;
         end
         hctb_pkg::OP_VISIT: begin
            state_in = sts.v_leaf ? hctb_pkg::OP_LEAF : hctb_pkg::OP_PUSH1;
         end
         hctb_pkg::OP_LEAF:  state_in = hctb_pkg::OP_POP;
         hctb_pkg::OP_PUSH1: state_in = hctb_pkg::OP_PUSH0;
         hctb_pkg::OP_PUSH0: state_in = hctb_pkg::OP_POP;
         hctb_pkg::OP_DONE:  state_in = hctb_pkg::OP_IDLE;
         default:            state_in = hctb_pkg::OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hctb_pkg::OP_IDLE;
         ctx_ff   <= CTX_HEAPIFY;
      end else begin
         state_ff <= state_in;
         ctx_ff   <= ctx_in;
      end
   end

   assign req_stall  = (state_ff != hctb_pkg::OP_IDLE);
   assign cmd.op     = state_ff;
   assign cmd.accept = req_valid && (state_ff == hctb_pkg::OP_IDLE);
   assign cmd.take_b = (ctx_ff == CTX_TAKE_B);

endmodule

// ===== rtl/hctb_datapath.sv =====
// Datapath of the code table builder: entry, heap, tree, stack and code memories.
`timescale 1ns / 1ps
module hctb_datapath #(
   parameter int SYMBOLS      = 256,
   parameter int MAX_CODE_LEN = 64,
   parameter int FREQ_BITS    = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  hctb_pkg::cmd_type cmd,
   output hctb_pkg::sts_type sts,
   input  logic              req_cmd,
   input  logic [7:0]        req_symbol,
   input  logic [31:0]       req_frequency,
   input  logic [7:0]        req_read_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_symbol,
   output logic [5:0]        rsp_code_len,
   output logic [63:0]       rsp_code_bits,
   output logic [1:0]        rsp_status
);

   localparam int WW      = hctb_pkg::WEIGHT_W;
   localparam int CW      = hctb_pkg::CODE_W;
   localparam int HEAP_AW = (SYMBOLS > 2) ? $clog2(SYMBOLS) : 1;
   localparam int CNT_W   = $clog2(SYMBOLS + 1);
   localparam int NODES   = 2 * SYMBOLS - 1;
   localparam int NODE_W  = $clog2(NODES);
   localparam int DEPTH_W = (CNT_W > 7) ? CNT_W : 7;
   localparam int HEAP_W  = NODE_W + WW;
   localparam int STK_W   = NODE_W + DEPTH_W + CW;
   localparam int LEN_CAP = (MAX_CODE_LEN < 64) ? MAX_CODE_LEN : 63;
   localparam int IDX_W   = HEAP_AW + 2;

   // memories
   logic [7:0]            esym_mem [SYMBOLS];
   logic [HEAP_W-1:0]     heap_mem [SYMBOLS];
   logic [2*NODE_W-1:0]   kids_mem [NODES];
   logic [STK_W-1:0]      stk_mem  [SYMBOLS];
   logic [6+CW-1:0]       code_mem [256];

   logic [7:0]            esym_rd;
   logic [HEAP_W-1:0]     heap_rd;
   logic [2*NODE_W-1:0]   kids_rd;
   logic [STK_W-1:0]      stk_rd;
   logic [6+CW-1:0]       code_rd;

   // control registers
   logic [CNT_W-1:0]   n_ff, n_in, cnt_ff, cnt_in, sp_ff, sp_in;
   logic [HEAP_AW-1:0] k_ff, k_in, pos_ff, pos_in;
   logic [NODE_W-1:0]  next_ff, next_in;
   logic               built_ff, built_in, rok_ff, rok_in, rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rdst_ff, rdst_in;
   logic [HEAP_W-1:0]  x_ff, x_in, lch_ff, lch_in, a_ff, a_in, b_ff, b_in;

   // output payload
   logic [7:0]  osym_ff;
   logic [5:0]  olen_ff;
   logic [63:0] obits_ff;
   logic [1:0]  ost_ff;

   logic [CNT_W-1:0]   base, cnt_m1, sp_m1, n_m2;
   logic [IDX_W-1:0]   l_w, r_w;
   logic               l_ok, r_ok;
   logic [WW-1:0]      x_w, l_wt, r_wt, s_wt;
   logic               take_l, take_r;
   logic [HEAP_AW-1:0] parent;
   logic [NODE_W-1:0]  v_node;
   logic [DEPTH_W-1:0] v_d, v_d1;
   logic [CW-1:0]      v_bits, bit_d, mask;
   logic [5:0]         leaf_len;

   logic                esym_re, heap_re, kids_re, stk_re, code_re;
   logic [HEAP_AW-1:0]  esym_ra, heap_ra, stk_ra;
   logic [NODE_W-1:0]   kids_ra;
   logic [7:0]          code_ra;
   logic                esym_we, heap_we, kids_we, stk_we, code_we;
   logic [HEAP_AW-1:0]  esym_wa, heap_wa, stk_wa;
   logic [NODE_W-1:0]   kids_wa;
   logic [7:0]          code_wa;
   logic [HEAP_W-1:0]   heap_wd;
   logic [STK_W-1:0]    stk_wd;

   assign base   = built_ff ? CNT_W'(0) : n_ff;
   assign cnt_m1 = cnt_ff - CNT_W'(1);
   assign sp_m1  = sp_ff - CNT_W'(1);
   assign n_m2   = n_ff - CNT_W'(2);
   assign l_w    = {1'b0, pos_ff, 1'b1};
   assign r_w    = l_w + IDX_W'(1);
   assign l_ok   = l_w < IDX_W'(cnt_ff);
   assign r_ok   = r_w < IDX_W'(cnt_ff);
   assign parent = (pos_ff - HEAP_AW'(1)) >> 1;

   assign x_w    = x_ff[WW-1:0];
   assign l_wt   = lch_ff[WW-1:0];
   assign r_wt   = heap_rd[WW-1:0];
   assign take_l = l_wt < x_w;
   assign s_wt   = take_l ? l_wt : x_w;
   assign take_r = rok_ff && (r_wt < s_wt);

   assign v_node   = stk_rd[STK_W-1 -: NODE_W];
   assign v_d      = stk_rd[CW +: DEPTH_W];
   assign v_bits   = stk_rd[CW-1:0];
   assign v_d1     = v_d + DEPTH_W'(1);
   assign bit_d    = (v_d < DEPTH_W'(64)) ? (CW'(1) << v_d[5:0]) : CW'(0);
   assign leaf_len = (v_d < DEPTH_W'(LEN_CAP)) ? v_d[5:0] : 6'(LEN_CAP);
   assign mask     = (CW'(1) << leaf_len) - CW'(1);

   always_comb begin
      sts.sd_end   = !l_ok;
      sts.sd_stop  = !take_l && !take_r;
      sts.k_zero   = (k_ff == '0);
      sts.cnt_gt1  = cnt_ff > CNT_W'(1);
      sts.pu_root  = (pos_ff == '0);
      sts.pu_stop  = !(x_w < heap_rd[WW-1:0]);
      sts.sp_zero  = (sp_ff == '0);
      sts.v_leaf   = NODE_W'(n_ff) > v_node;
      sts.n_one    = (n_ff == CNT_W'(1));
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      n_in = n_ff; cnt_in = cnt_ff; sp_in = sp_ff; k_in = k_ff; pos_in = pos_ff;
      next_in = next_ff; built_in = built_ff; rok_in = rok_ff; rdst_in = rdst_ff;
      x_in = x_ff; lch_in = lch_ff; a_in = a_ff; b_in = b_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      esym_re = 1'b0; heap_re = 1'b0; kids_re = 1'b0; stk_re = 1'b0; code_re = 1'b0;
      esym_ra = req_read_index[HEAP_AW-1:0]; heap_ra = '0; stk_ra = sp_m1[HEAP_AW-1:0];
      kids_ra = v_node; code_ra = esym_rd;
      esym_we = 1'b0; heap_we = 1'b0; kids_we = 1'b0; stk_we = 1'b0; code_we = 1'b0;
      esym_wa = base[HEAP_AW-1:0]; heap_wa = pos_ff; stk_wa = sp_ff[HEAP_AW-1:0];
      kids_wa = next_ff; code_wa = esym_rd;
      heap_wd = x_ff; stk_wd = '0;
      case (cmd.op)
         hctb_pkg::OP_IDLE: begin
            if (cmd.accept && req_cmd == hctb_pkg::CMD_LOAD) begin
               built_in = 1'b0;
               n_in     = base;
               if (base < CNT_W'(SYMBOLS)) begin
                  esym_we = 1'b1;
                  heap_we = 1'b1;
                  heap_wa = base[HEAP_AW-1:0];
                  heap_wd = {NODE_W'(base), WW'(req_frequency[FREQ_BITS-1:0])};
                  n_in    = base + CNT_W'(1);
               end
            end else if (cmd.accept) begin
               esym_re = 1'b1;
               if (!built_ff) begin
                  rdst_in = hctb_pkg::STAT_NOT_BUILT;
               end else if (int'(req_read_index) >= int'(n_ff)) begin
                  rdst_in = hctb_pkg::STAT_RANGE;
               end else begin
                  rdst_in = hctb_pkg::STAT_OK;
               end
            end
         end
         hctb_pkg::OP_RD_SYM: code_re = 1'b1;
         hctb_pkg::OP_HF_START: begin
            cnt_in  = n_ff;
            k_in    = HEAP_AW'(n_m2 >> 1);
            next_in = NODE_W'(n_ff);
         end
         hctb_pkg::OP_HF_LD: begin
            heap_re = 1'b1;
            heap_ra = k_ff;
         end
         hctb_pkg::OP_HF_LAT: begin
            x_in   = heap_rd;
            pos_in = k_ff;
         end
         hctb_pkg::OP_HF_NEXT: begin
            if (k_ff != '0) k_in = k_ff - HEAP_AW'(1);
         end
         hctb_pkg::OP_SD_RL: begin
            if (l_ok) begin
               heap_re = 1'b1;
               heap_ra = l_w[HEAP_AW-1:0];
            end else begin
               heap_we = 1'b1;
            end
         end
         hctb_pkg::OP_SD_RR: begin
            lch_in = heap_rd;
            rok_in = r_ok;
            if (r_ok) begin
               heap_re = 1'b1;
               heap_ra = r_w[HEAP_AW-1:0];
            end
         end
         hctb_pkg::OP_SD_CMP: begin
            heap_we = 1'b1;
            if (take_r) begin
               heap_wd = heap_rd;
               pos_in  = r_w[HEAP_AW-1:0];
            end else if (take_l) begin
               heap_wd = lch_ff;
               pos_in  = l_w[HEAP_AW-1:0];
            end
         end
         hctb_pkg::OP_TM_TOP: begin
            heap_re = 1'b1;
            heap_ra = '0;
         end
         hctb_pkg::OP_TM_LAST: begin
            if (cmd.take_b) b_in = heap_rd;
            else a_in = heap_rd;
            heap_re = 1'b1;
            heap_ra = cnt_m1[HEAP_AW-1:0];
         end
         hctb_pkg::OP_TM_LAT: begin
            x_in   = heap_rd;
            cnt_in = cnt_m1;
            pos_in = '0;
         end
         hctb_pkg::OP_PUT: begin
            kids_we = 1'b1;
            x_in    = {next_ff, a_ff[WW-1:0] + b_ff[WW-1:0]};
            pos_in  = cnt_ff[HEAP_AW-1:0];
            cnt_in  = cnt_ff + CNT_W'(1);
            next_in = next_ff + NODE_W'(1);
         end
         hctb_pkg::OP_PU: begin
            if (pos_ff == '0) begin
               heap_we = 1'b1;
            end else begin
               heap_re = 1'b1;
               heap_ra = parent;
            end
         end
         hctb_pkg::OP_PU_CMP: begin
            heap_we = 1'b1;
            if (x_w < heap_rd[WW-1:0]) begin
               heap_wd = heap_rd;
               pos_in  = parent;
            end
         end
         hctb_pkg::OP_ROOT_RD: begin
            heap_re = 1'b1;
            heap_ra = '0;
         end
         hctb_pkg::OP_ROOT_LAT: begin
            stk_we = 1'b1;
            stk_wa = '0;
            stk_wd = {heap_rd[HEAP_W-1 -: NODE_W], DEPTH_W'(0), CW'(0)};
            sp_in  = CNT_W'(1);
         end
         hctb_pkg::OP_POP: begin
            if (sp_ff != '0) begin
               stk_re = 1'b1;
               sp_in  = sp_m1;
            end
         end
         hctb_pkg::OP_VISIT: begin
            if (NODE_W'(n_ff) > v_node) begin
               esym_re = 1'b1;
               esym_ra = v_node[HEAP_AW-1:0];
            end else begin
               kids_re = 1'b1;
            end
         end
         hctb_pkg::OP_LEAF: code_we = 1'b1;
         hctb_pkg::OP_PUSH1: begin
            stk_we = 1'b1;
            stk_wd = {kids_rd[NODE_W-1:0], v_d1, v_bits | bit_d};
            sp_in  = sp_ff + CNT_W'(1);
         end
         hctb_pkg::OP_PUSH0: begin
            stk_we = 1'b1;
            stk_wd = {kids_rd[2*NODE_W-1 -: NODE_W], v_d1, v_bits};
            sp_in  = sp_ff + CNT_W'(1);
         end
         hctb_pkg::OP_DONE: built_in = 1'b1;
         hctb_pkg::OP_RD_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (esym_we) esym_mem[esym_wa] <= req_symbol;
      if (esym_re) esym_rd <= esym_mem[esym_ra];
   end

   always_ff @(posedge clock) begin
      if (heap_we) heap_mem[heap_wa] <= heap_wd;
      if (heap_re) heap_rd <= heap_mem[heap_ra];
   end

   always_ff @(posedge clock) begin
      if (kids_we) kids_mem[kids_wa] <= {a_ff[HEAP_W-1 -: NODE_W], b_ff[HEAP_W-1 -: NODE_W]};
      if (kids_re) kids_rd <= kids_mem[kids_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      if (stk_re) stk_rd <= stk_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      if (code_we) code_mem[code_wa] <= {leaf_len, v_bits & mask};
      if (code_re) code_rd <= code_mem[code_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0; cnt_ff <= '0; sp_ff <= '0; built_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         n_ff <= n_in; cnt_ff <= cnt_in; sp_ff <= sp_in; built_ff <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in; pos_ff <= pos_in; next_ff <= next_in; rok_ff <= rok_in;
      rdst_ff <= rdst_in; x_ff <= x_in; lch_ff <= lch_in; a_ff <= a_in; b_ff <= b_in;
      if (cmd.op == hctb_pkg::OP_RD_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         ost_ff <= rdst_ff;
         if (rdst_ff == hctb_pkg::STAT_OK) begin
            osym_ff  <= esym_rd;
            olen_ff  <= code_rd[6+CW-1 -: 6];
            obits_ff <= code_rd[CW-1:0];
         end else begin
            osym_ff  <= '0;
            olen_ff  <= '0;
            obits_ff <= '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_symbol = osym_ff;
   assign rsp_code_len   = olen_ff;
   assign rsp_code_bits  = obits_ff;
   assign rsp_status     = ost_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(SYMBOLS)) else $error("heap count beyond capacity");
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CNT_W'(SYMBOLS)) else $error("walk stack overflow");
   a_n_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(SYMBOLS)) else $error("entry count beyond capacity");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == hctb_pkg::OP_PUSH1) |-> (sp_ff < CNT_W'(SYMBOLS)))
      else $error("push into full walk stack");
`endif

endmodule

// ===== rtl/huffman_code_table_builder.sv =====
// Top level of the Huffman code table builder: sequencer plus datapath.
`timescale 1ns / 1ps
// Load requests (cmd 0) store one symbol byte and its frequency and are taken
// one per cycle; the load flagged is_last also starts the build, and the
// block stalls requests until the build is finished. The build runs bottom-up
// heapify, n-1 merges of the two smallest nodes (each a pair of sift-downs and
// one sift-up), then a depth-first walk of the tree. A load after a finished
// build drops the table and starts a new set. Read requests (cmd 1) return the
// code of an entry by load index; the response is registered after an entry
// memory read and then a code memory read, waiting while a previous response
// is stalled, and the next request is taken only once it is registered;
// status 1 means no table is built, status 2 an index past the loaded count.
// Entries sharing a symbol byte all report the code of the last such leaf
// reached by the walk.
module huffman_code_table_builder #(
   parameter int SYMBOLS      = 256,
   parameter int MAX_CODE_LEN = 64,
   parameter int FREQ_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_symbol,
   input  logic [31:0] req_frequency,
   input  logic        req_is_last,
   input  logic [7:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_symbol,
   output logic [5:0]  rsp_code_len,
   output logic [63:0] rsp_code_bits,
   output logic [1:0]  rsp_status
);

   hctb_pkg::cmd_type cmd;
   hctb_pkg::sts_type sts;

   // sequence requests and build steps
   hctb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_cmd     (req_cmd),
      .req_is_last (req_is_last),
      .req_stall   (req_stall),
      .cmd         (cmd),
      .sts         (sts)
   );

   // hold memories, heap registers and the response register
   hctb_datapath #(
      .SYMBOLS      (SYMBOLS),
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .FREQ_BITS    (FREQ_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_cmd        (req_cmd),
      .req_symbol     (req_symbol),
      .req_frequency  (req_frequency),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_symbol (rsp_out_symbol),
      .rsp_code_len   (rsp_code_len),
      .rsp_code_bits  (rsp_code_bits),
      .rsp_status     (rsp_status)
   );

endmodule
